### hdl/bloom_filter_djb2_splitmix_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Bloom filter unit
// Concurrent assertion wrappers with clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_DJB2_SPLITMIX_UNIT_ASSERT_SVH
`define BLOOM_FILTER_DJB2_SPLITMIX_UNIT_ASSERT_SVH

// Same-cycle implication
`define BFDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfds assertion failed");

// Next-cycle implication
`define BFDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfds assertion failed");

`endif

### hdl/bfds_pkg.sv
// ----------------------------------------------------------------------------
// bfds_pkg
// Sizes, hash constants and store geometry of the Bloom filter unit.
// ----------------------------------------------------------------------------
package bfds_pkg;

  // Filter geometry (FILTER_BITS is a power of two, at least ROW_W)
  localparam int unsigned FILTER_BITS = 8192;
  localparam int unsigned NUM_HASHES  = 4;
  localparam int unsigned IDX_W       = $clog2(FILTER_BITS);
  localparam int unsigned ROW_W       = 32;
  localparam int unsigned ROW_BIT_W   = $clog2(ROW_W);
  localparam int unsigned ROWS        = FILTER_BITS / ROW_W;
  localparam int unsigned ROW_AW      = $clog2(ROWS);
  localparam int unsigned RND_W       = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

  // Hash datapath
  localparam int unsigned HASH_W    = 64;
  localparam int unsigned HALF_W    = HASH_W / 2;
  localparam int unsigned DJB_SHIFT = 5;
  localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
  localparam logic [HASH_W-1:0] MIX_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [HASH_W-1:0] MIX_C1    = 64'hbf58476d1ce4e5b9;
  localparam logic [HASH_W-1:0] MIX_C2    = 64'h94d049bb133111eb;
  localparam int unsigned SHIFT_A = 30;
  localparam int unsigned SHIFT_B = 27;
  localparam int unsigned SHIFT_C = 31;

  // 64x64 low product in three 32x32 partial products
  localparam int unsigned STEP_W    = 2;
  localparam logic [STEP_W-1:0] STEP_LL = 2'd0;
  localparam logic [STEP_W-1:0] STEP_HL = 2'd1;
  localparam logic [STEP_W-1:0] STEP_LH = 2'd2;

  // Commands
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

endpackage

### hdl/bfds_if.sv
// ----------------------------------------------------------------------------
// Bloom filter channels
// Key word channel and query answer channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfds_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] key_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, command, key_byte, has_byte, last, input ready);
  modport sink   (input valid, command, key_byte, has_byte, last, output ready);
endinterface

interface bfds_out_if;
  logic valid;
  logic ready;
  logic maybe_present;

  modport source (output valid, maybe_present, input ready);
  modport sink   (input valid, maybe_present, output ready);
endinterface

### hdl/bfds_ram.sv
// ----------------------------------------------------------------------------
// bfds_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bloom_filter_djb2_splitmix_unit.sv
// Key words without last only update the running hash; a last word starts NUM_HASHES
//   hash rounds (four), during which the input is not ready, each paced by the shared
//   32x32 multiplier (3 steps per splitmix product) and the filter RAM read.
// A query answer is loaded in S_DONE after the last round, once the output is free; inserts give no word.
// Reset: running hash returns to 5381 and all 256 row valid flags clear at once,
//   so the filter reads as empty from the first cycle after reset.
// ----------------------------------------------------------------------------
// bloom_filter_djb2_splitmix_unit
// Bloom filter over byte keys: djb2 running hash, splitmix64 bit selection,
// bit store in a 256 x 32 RAM with per-row valid flags.
// ----------------------------------------------------------------------------
module bloom_filter_djb2_splitmix_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  bfds_in_if.sink           in_i,
  bfds_out_if.source        out_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ADD  = 8'b0000_0010,
    S_MUL1 = 8'b0000_0100,
    S_XS2  = 8'b0000_1000,
    S_MUL2 = 8'b0001_0000,
    S_PICK = 8'b0010_0000,
    S_CHK  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  localparam int unsigned HW = bfds_pkg::HASH_W;
  localparam int unsigned HF = bfds_pkg::HALF_W;

  state_e state_q, state_d;

  logic [HW-1:0]                   hash_q, hash_d;
  logic [HW-1:0]                   seed_q, seed_d;
  logic [HW-1:0]                   mul_a_q, mul_a_d;
  logic [HW-1:0]                   acc_q, acc_d;
  logic [bfds_pkg::STEP_W-1:0]     step_q, step_d;
  logic [bfds_pkg::RND_W-1:0]      round_q, round_d;
  logic                            cmd_q, cmd_d;
  logic                            all_set_q, all_set_d;
  logic [bfds_pkg::ROW_AW-1:0]     row_q, row_d;
  logic [bfds_pkg::ROW_BIT_W-1:0]  bit_q, bit_d;
  logic [bfds_pkg::ROWS-1:0]       row_valid_q, row_valid_d;
  logic                            out_valid_q, out_valid_d;
  logic                            present_q, present_d;

  logic                            in_acc;
  logic                            out_free;
  logic [HW-1:0]                   hash_next;
  logic [HW-1:0]                   seed_add;
  logic [HW-1:0]                   mul_b;
  logic [HF-1:0]                   mul_x, mul_y;
  logic [HW-1:0]                   prod;
  logic [HW-1:0]                   pick_z;
  logic [bfds_pkg::IDX_W-1:0]      pick_idx;
  logic [bfds_pkg::ROW_W-1:0]      rdata;
  logic [bfds_pkg::ROW_W-1:0]      row_data;
  logic                            ram_we, ram_re;
  logic [bfds_pkg::ROW_W-1:0]      ram_wdata;

  assign in_i.ready    = (state_q == S_IDLE);
  assign in_acc        = in_i.valid & in_i.ready;
  assign out_free      = ~out_valid_q | out_o.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.maybe_present = present_q;

  // djb2 step: hash * 33 + byte
  assign hash_next = in_i.has_byte
                   ? (hash_q << bfds_pkg::DJB_SHIFT) + hash_q + HW'(in_i.key_byte)
                   : hash_q;

  assign seed_add = seed_q + bfds_pkg::MIX_GAMMA;

  // Shared partial-product multiplier
  assign mul_b = (state_q == S_MUL1) ? bfds_pkg::MIX_C1 : bfds_pkg::MIX_C2;
  always_comb begin
    mul_x = mul_a_q[HF-1:0];
    mul_y = mul_b[HF-1:0];
    unique case (step_q)
      bfds_pkg::STEP_HL: mul_x = mul_a_q[HW-1:HF];
      bfds_pkg::STEP_LH: mul_y = mul_b[HW-1:HF];
      default: ;
    endcase
  end
  assign prod = HW'(mul_x) * HW'(mul_y);

  // Final splitmix xorshift and bit index
  assign pick_z   = acc_q ^ (acc_q >> bfds_pkg::SHIFT_C);
  assign pick_idx = pick_z[bfds_pkg::IDX_W-1:0];

  // Row never written reads as empty
  assign row_data = row_valid_q[row_q] ? rdata : '0;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    hash_d      = hash_q;
    seed_d      = seed_q;
    mul_a_d     = mul_a_q;
    acc_d       = acc_q;
    step_d      = step_q;
    round_d     = round_q;
    cmd_d       = cmd_q;
    all_set_d   = all_set_q;
    row_d       = row_q;
    bit_d       = bit_q;
    row_valid_d = row_valid_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    present_d   = present_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_wdata   = row_data | (bfds_pkg::ROW_W'(1) << bit_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.last) begin
            seed_d    = hash_next;
            hash_d    = bfds_pkg::HASH_SEED;
            cmd_d     = in_i.command;
            round_d   = '0;
            all_set_d = 1'b1;
            state_d   = S_ADD;
          end else begin
            hash_d = hash_next;
          end
        end
      end
      S_ADD: begin
        seed_d  = seed_add;
        mul_a_d = seed_add ^ (seed_add >> bfds_pkg::SHIFT_A);
        step_d  = bfds_pkg::STEP_LL;
        state_d = S_MUL1;
      end
      S_MUL1, S_MUL2: begin
        if (step_q == bfds_pkg::STEP_LL) begin
          acc_d = prod;
        end else begin
          acc_d = {acc_q[HW-1:HF] + prod[HF-1:0], acc_q[HF-1:0]};
        end
        step_d = step_q + 1'b1;
        if (step_q == bfds_pkg::STEP_LH) begin
          state_d = (state_q == S_MUL1) ? S_XS2 : S_PICK;
        end
      end
      S_XS2: begin
        mul_a_d = acc_q ^ (acc_q >> bfds_pkg::SHIFT_B);
        step_d  = bfds_pkg::STEP_LL;
        state_d = S_MUL2;
      end
      S_PICK: begin
        // Issue row read; RAM data arrives next cycle
        row_d   = pick_idx[bfds_pkg::IDX_W-1:bfds_pkg::ROW_BIT_W];
        bit_d   = pick_idx[bfds_pkg::ROW_BIT_W-1:0];
        ram_re  = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        // Read-modify-write; the next store access waits for the next round's S_PICK
        if (cmd_q == bfds_pkg::CMD_INSERT) begin
          ram_we             = 1'b1;
          row_valid_d[row_q] = 1'b1;
        end else begin
          all_set_d = all_set_q & row_data[bit_q];
        end
        if (round_q == bfds_pkg::RND_W'(bfds_pkg::NUM_HASHES - 1)) begin
          state_d = (cmd_q == bfds_pkg::CMD_QUERY) ? S_DONE : S_IDLE;
        end else begin
          round_d = round_q + 1'b1;
          state_d = S_ADD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          present_d   = all_set_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hash_q      <= bfds_pkg::HASH_SEED;
      step_q      <= '0;
      round_q     <= '0;
      cmd_q       <= bfds_pkg::CMD_INSERT;
      all_set_q   <= 1'b1;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      step_q      <= step_d;
      round_q     <= round_d;
      cmd_q       <= cmd_d;
      all_set_q   <= all_set_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    seed_q    <= seed_d;
    mul_a_q   <= mul_a_d;
    acc_q     <= acc_d;
    row_q     <= row_d;
    bit_q     <= bit_d;
    present_q <= present_d;
  end

  // Filter bit store
  bfds_ram #(
    .WIDTH (bfds_pkg::ROW_W),
    .DEPTH (bfds_pkg::ROWS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (row_d),
    .rdata_o (rdata)
  );

endmodule

### hdl/bfds_checker.sv
// ----------------------------------------------------------------------------
// bfds_checker
// Port-level checks of the Bloom filter unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "bloom_filter_djb2_splitmix_unit_assert.svh"

module bfds_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_present_i
);

  logic in_acc;
  assign in_acc = in_valid_i & in_ready_i;

  // Stalled answer word stays put
  `BFDS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `BFDS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_present_i))

  // Key finish starts the hash rounds; mid-key words keep streaming
  `BFDS_ASSERT_NEXT(a_last_busy, clk_i, rst_ni, in_acc && in_last_i, !in_ready_i)
  `BFDS_ASSERT_NEXT(a_byte_stream, clk_i, rst_ni, in_acc && !in_last_i, in_ready_i)

  // An answer never directly follows an accepted word
  `BFDS_ASSERT_NOW(a_no_early_out, clk_i, rst_ni, $rose(out_valid_i), !$past(in_acc))

endmodule

bind bloom_filter_djb2_splitmix_unit bfds_checker u_bfds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_last_i     (in_i.last),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_present_i (out_o.maybe_present)
);
